/* src/islt_pkg.sv */
// shared types, codes and defaults of the innermost span lookup table
package islt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ID_BITS     = 16;

    // request modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_POS    = 2'd1;
    localparam logic [1:0] MODE_SEM    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        focus_valid;
        logic [31:0] focus_offset;
        logic [15:0] focus_size;
        logic        span_valid;
        logic [31:0] span_offset;
        logic [31:0] span_size;
        logic [15:0] semantic_id;
        logic [31:0] query_offset;
    } islt_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_semantic;
        logic        found_focus_valid;
        logic [31:0] found_focus_offset;
        logic [15:0] found_focus_size;
        logic [31:0] found_span_offset;
        logic [31:0] found_span_size;
    } islt_result_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic fetch;
        logic finish;
    } islt_cmd_t;

    typedef struct packed {
        logic query;
        logic empty;
        logic scan_last;
        logic pipe_idle;
        logic have;
    } islt_sts_t;

endpackage

/* src/islt_if.sv */
// request and response channel interfaces
interface islt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        focus_valid;
    logic [31:0] focus_offset;
    logic [15:0] focus_size;
    logic        span_valid;
    logic [31:0] span_offset;
    logic [31:0] span_size;
    logic [15:0] semantic_id;
    logic [31:0] query_offset;

    modport source (
        output valid, mode, focus_valid, focus_offset, focus_size, span_valid,
               span_offset, span_size, semantic_id, query_offset,
        input  ready
    );
    modport sink (
        input  valid, mode, focus_valid, focus_offset, focus_size, span_valid,
               span_offset, span_size, semantic_id, query_offset,
        output ready
    );
endinterface

interface islt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] found_semantic;
    logic        found_focus_valid;
    logic [31:0] found_focus_offset;
    logic [15:0] found_focus_size;
    logic [31:0] found_span_offset;
    logic [31:0] found_span_size;

    modport source (
        output valid, status, found_semantic, found_focus_valid, found_focus_offset,
               found_focus_size, found_span_offset, found_span_size,
        input  ready
    );
    modport sink (
        input  valid, status, found_semantic, found_focus_valid, found_focus_offset,
               found_focus_size, found_span_offset, found_span_size,
        output ready
    );
endinterface

/* src/islt_ram.sv */
// generic single-port-write ram with registered read
module islt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* src/islt_datapath.sv */
// table storage, scan pipeline, best-entry tracking and result register
module islt_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  islt_pkg::islt_item_t item,
    input  islt_pkg::islt_cmd_t  cmd,
    output islt_pkg::islt_sts_t  sts,
    output islt_pkg::islt_result_t result
);
    import islt_pkg::*;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 113 + ID_BITS;

    // item registers
    logic [1:0]         mode_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        q_reg;
    logic [1:0]         ins_st_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   scan_idx_reg;

    // read and evaluate stages
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               ev_vld_reg;
    logic [IDX_W-1:0]   ev_idx_reg;
    logic               ev_hit_reg;
    logic               ev_focus_reg;
    logic [31:0]        ev_ext_reg;
    logic               ev_match_reg;

    // best candidate so far
    logic               have_reg, have_next;
    logic               best_focus_reg, best_focus_next;
    logic [31:0]        best_ext_reg, best_ext_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;

    islt_result_t       result_reg, result_next;

    logic [31:0]        id_wide;
    logic [ID_BITS-1:0] id_in;
    logic               full;
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic               rd_fv;
    logic [31:0]        rd_fo;
    logic [15:0]        rd_fs;
    logic [31:0]        rd_so;
    logic [31:0]        rd_ss;
    logic [ID_BITS-1:0] rd_sem;
    logic [31:0]        sem_wide;
    logic [32:0]        f_end;
    logic [32:0]        s_end;
    logic               cf;
    logic               cs;
    logic               take;

    assign id_wide = 32'(item.semantic_id);
    assign id_in   = id_wide[ID_BITS-1:0];
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en   = cmd.load && (item.mode == MODE_INSERT) && item.span_valid && !full;
    assign wr_data = {item.focus_valid,
                      item.focus_valid ? item.focus_offset : 32'd0,
                      item.focus_valid ? item.focus_size : 16'd0,
                      item.span_offset, item.span_size, id_in};

    assign rd_en   = cmd.scan_step || cmd.fetch;
    assign rd_addr = cmd.fetch ? best_idx_reg : scan_idx_reg;

    islt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sem   = rd_data[ID_BITS-1:0];
    assign rd_ss    = rd_data[ID_BITS+:32];
    assign rd_so    = rd_data[ID_BITS+32+:32];
    assign rd_fs    = rd_data[ID_BITS+64+:16];
    assign rd_fo    = rd_data[ID_BITS+80+:32];
    assign rd_fv    = rd_data[ID_BITS+112];
    assign sem_wide = 32'(rd_sem);

    // containment, end sums one bit wider so they never wrap
    assign f_end = {1'b0, rd_fo} + {17'd0, rd_fs};
    assign s_end = {1'b0, rd_so} + {1'b0, rd_ss};
    assign cf    = rd_fv && (q_reg >= rd_fo) && ({1'b0, q_reg} < f_end);
    assign cs    = (q_reg >= rd_so) && ({1'b0, q_reg} < s_end);

    assign count_next = wr_en ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        if (mode_reg == MODE_POS)
        begin
            take = ev_vld_reg && ev_hit_reg &&
                   (!have_reg || (ev_focus_reg && !best_focus_reg) ||
                    ((ev_focus_reg == best_focus_reg) && (ev_ext_reg < best_ext_reg)));
        end
        else
        begin
            take = ev_vld_reg && ev_match_reg && !have_reg;
        end
    end

    always_comb
    begin
        have_next       = have_reg;
        best_focus_next = best_focus_reg;
        best_ext_next   = best_ext_reg;
        best_idx_next   = best_idx_reg;
        if (cmd.load)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next       = 1'b1;
            best_focus_next = ev_focus_reg;
            best_ext_next   = ev_ext_reg;
            best_idx_next   = ev_idx_reg;
        end
    end

    always_comb
    begin
        result_next = '0;
        case (mode_reg)
            MODE_INSERT:
            begin
                result_next.status = ins_st_reg;
            end
            MODE_POS:
            begin
                if (have_reg)
                begin
                    result_next.status         = ST_OK;
                    result_next.found_semantic = sem_wide[15:0];
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            MODE_SEM:
            begin
                if (have_reg)
                begin
                    result_next.status             = ST_OK;
                    result_next.found_semantic     = sem_wide[15:0];
                    result_next.found_focus_valid  = rd_fv;
                    result_next.found_focus_offset = rd_fo;
                    result_next.found_focus_size   = rd_fs;
                    result_next.found_span_offset  = rd_so;
                    result_next.found_span_size    = rd_ss;
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                result_next.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
            ev_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_vld_reg <= cmd.scan_step;
            ev_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg     <= item.mode;
            id_reg       <= id_in;
            q_reg        <= item.query_offset;
            scan_idx_reg <= '0;
            if (!item.span_valid)
            begin
                ins_st_reg <= ST_IGNORED;
            end
            else if (full)
            begin
                ins_st_reg <= ST_FULL;
            end
            else
            begin
                ins_st_reg <= ST_OK;
            end
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        rd_idx_reg     <= scan_idx_reg;
        ev_idx_reg     <= rd_idx_reg;
        ev_hit_reg     <= cf || cs;
        ev_focus_reg   <= cf;
        ev_ext_reg     <= cf ? {16'd0, rd_fs} : rd_ss;
        ev_match_reg   <= (rd_sem == id_reg);
        have_reg       <= have_next;
        best_focus_reg <= best_focus_next;
        best_ext_reg   <= best_ext_next;
        best_idx_reg   <= best_idx_next;
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign sts.query     = (mode_reg == MODE_POS) || (mode_reg == MODE_SEM);
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_last = (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1));
    assign sts.pipe_idle = !rd_vld_reg && !ev_vld_reg;
    assign sts.have      = have_reg;
    assign result        = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (CNT_W'(scan_idx_reg) < count_reg))
        else $error("scan reads an unwritten entry");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> (have_reg && (CNT_W'(best_idx_reg) < count_reg)))
        else $error("fetch of an invalid best entry");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!rd_vld_reg && !ev_vld_reg))
        else $error("insert while a scan is in flight");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count moved by more than one");
endmodule

/* src/islt_ctrl.sv */
// sequencer for insert, scan, fetch and result hand-off
module islt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  islt_pkg::islt_sts_t sts,
    output islt_pkg::islt_cmd_t cmd
);
    import islt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (sts.query && !sts.empty) ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sts.pipe_idle)
                begin
                    state_next = sts.have ? S_FETCH : S_FINISH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

/* src/innermost_span_lookup_table.sv */
// top level of the innermost span lookup table
// sequence: insert, undefined mode or query of an empty table goes from accept through the start and finish
//   states; a query runs start, scan over the stored entries, drain, fetch when a hit entry is re-read, finish
// pacing: a new word is not taken until the last one reaches finish, set by the single table read port scanning
//   one entry per cycle; one more word may be taken while a result waits, then input stalls
// reset: clears the entry count and the sequencer; table contents are not cleared
module innermost_span_lookup_table #(
    parameter int TABLE_DEPTH = islt_pkg::DEF_TABLE_DEPTH,
    parameter int ID_BITS     = islt_pkg::DEF_ID_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    islt_req_if.sink   req,
    islt_rsp_if.source rsp
);
    import islt_pkg::*;

    islt_item_t   item;
    islt_result_t result;
    islt_cmd_t    cmd;
    islt_sts_t    sts;

    // request word flattened for the datapath
    assign item.mode         = req.mode;
    assign item.focus_valid  = req.focus_valid;
    assign item.focus_offset = req.focus_offset;
    assign item.focus_size   = req.focus_size;
    assign item.span_valid   = req.span_valid;
    assign item.span_offset  = req.span_offset;
    assign item.span_size    = req.span_size;
    assign item.semantic_id  = req.semantic_id;
    assign item.query_offset = req.query_offset;

    // sequencer: accepts a word only when idle, holds the result register
    // valid until taken, and a new request may come in while it waits
    islt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: table ram, two-stage scan evaluation, best-entry tracking
    islt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    // response word straight from the result register
    assign rsp.status             = result.status;
    assign rsp.found_semantic     = result.found_semantic;
    assign rsp.found_focus_valid  = result.found_focus_valid;
    assign rsp.found_focus_offset = result.found_focus_offset;
    assign rsp.found_focus_size   = result.found_focus_size;
    assign rsp.found_span_offset  = result.found_span_offset;
    assign rsp.found_span_size    = result.found_span_size;
endmodule
